>>> rtl/rfd_pkg.sv
package rfd_pkg;

  // Bytes kept from one frame; only the first sixteen are decoded.
  localparam int STORED_BYTES = 16;
  localparam int DECODED_BYTES = 16;
  localparam int STORE_AW = $clog2(STORED_BYTES);
  localparam int WPOS_W = $clog2(STORED_BYTES + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_H = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_V = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_X_ZERO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_Y_ZERO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_LIMIT = 3'd4;

  localparam logic [7:0] DEADZONE_H_RESET = 8'd5;
  localparam logic [7:0] DEADZONE_V_RESET = 8'd10;
  localparam logic [9:0] LEFT_X_ZERO_RESET = 10'd23;
  localparam logic [9:0] LEFT_Y_ZERO_RESET = 10'd10;
  localparam logic [9:0] STICK_LIMIT_RESET = 10'd660;

  typedef enum logic {
    ITEM_BYTE,
    ITEM_IDLE
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

>>> rtl/rfd_front.sv
module rfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                idle,
  input  logic [7:0]          rx_byte,
  input  logic                pop,
  output logic                busy,
  output rfd_pkg::queue_head_t head
);

  rfd_pkg::item_t                 queue [rfd_pkg::QUEUE_DEPTH];
  logic [rfd_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [rfd_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [rfd_pkg::QUEUE_CW-1:0]   count;
  logic                           push;
  logic                           do_pop;
  rfd_pkg::item_t                 incoming;

  localparam logic [rfd_pkg::QUEUE_AW-1:0] LAST_SLOT =
    rfd_pkg::QUEUE_AW'(rfd_pkg::QUEUE_DEPTH - 1);
  localparam logic [rfd_pkg::QUEUE_CW-1:0] FULL_COUNT =
    rfd_pkg::QUEUE_CW'(rfd_pkg::QUEUE_DEPTH);

  assign busy = (count == FULL_COUNT);
  assign push = start && !busy;
  assign do_pop = pop && (count != '0);

  always_comb begin
    incoming.kind = idle ? rfd_pkg::ITEM_IDLE : rfd_pkg::ITEM_BYTE;
    incoming.data = rx_byte;
  end

  assign head.valid = (count != '0);
  assign head.item = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        queue[wr_ptr] <= incoming;
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

>>> rtl/rfd_back.sv
module rfd_back (
  input  logic                               clk,
  input  logic                               rst,
  input  rfd_pkg::queue_head_t               head,
  output logic                               pop,
  input  logic                               cfg_we,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               done,
  output logic signed [10:0]                 right_x,
  output logic signed [10:0]                 right_y,
  output logic signed [10:0]                 left_x,
  output logic signed [10:0]                 left_y,
  output logic [1:0]                         switch_left,
  output logic [1:0]                         switch_right,
  output logic signed [15:0]                 mouse_x,
  output logic signed [15:0]                 mouse_y,
  output logic [7:0]                         mouse_left,
  output logic [7:0]                         mouse_right,
  output logic [15:0]                        key_bits,
  output logic                               frame_rejected
);

  typedef struct packed {
    logic signed [10:0] rx;
    logic signed [10:0] ry;
    logic signed [10:0] lx;
    logic signed [10:0] ly;
    logic [1:0]         sw_l;
    logic [1:0]         sw_r;
    logic [15:0]        mx;
    logic [15:0]        my;
    logic [7:0]         ml;
    logic [7:0]         mr;
    logic [15:0]        key;
  } decode_t;

  logic [7:0]                  deadzone_h;
  logic [7:0]                  deadzone_v;
  logic [9:0]                  left_x_zero;
  logic [9:0]                  left_y_zero;
  logic [9:0]                  stick_limit;

  logic [7:0]                  store [rfd_pkg::STORED_BYTES];
  logic [rfd_pkg::WPOS_W-1:0]  wpos;

  logic [7:0]                  b [rfd_pkg::DECODED_BYTES];
  logic [10:0]                 raw0, raw1, raw2, raw3;
  decode_t                     dec_next;
  decode_t                     dec;
  logic                        dec_valid;

  logic [10:0]                 mag_rx, mag_ry, mag_lx, mag_ly;
  logic                        zero_lx, zero_ly;
  logic                        reject;

  function automatic logic signed [10:0] shrink(input logic signed [10:0] v,
                                                input logic [7:0] z);
    logic signed [11:0] ve;
    logic signed [11:0] zs;
    logic signed [11:0] r;
    ve = 12'(v);
    zs = $signed({4'b0000, z});
    if (ve > zs) begin
      r = ve - zs;
    end else if (ve < -zs) begin
      r = ve + zs;
    end else begin
      r = '0;
    end
    return r[10:0];
  endfunction

  function automatic logic [10:0] magnitude(input logic signed [10:0] v);
    return v[10] ? 11'(-v) : 11'(v);
  endfunction

  // The back end never stalls, so the queue head is taken whenever present.
  assign pop = head.valid;

  always_comb begin
    for (int i = 0; i < rfd_pkg::DECODED_BYTES; i++) begin
      b[i] = store[i];
    end
    raw0 = {b[1][2:0], b[0]};
    raw1 = {b[2][5:0], b[1][7:3]};
    raw2 = {b[4][0], b[3], b[2][7:6]};
    raw3 = {b[5][3:0], b[4][7:1]};
    // Subtracting the 1024 center of an 11-bit code flips its top bit.
    dec_next.rx = shrink($signed({~raw0[10], raw0[9:0]}), deadzone_h);
    dec_next.ry = shrink($signed({~raw1[10], raw1[9:0]}), deadzone_v);
    dec_next.lx = shrink($signed({~raw2[10], raw2[9:0]}), deadzone_h);
    dec_next.ly = shrink($signed({~raw3[10], raw3[9:0]}), deadzone_v);
    dec_next.sw_l = b[5][7:6];
    dec_next.sw_r = b[5][5:4];
    dec_next.mx = {b[7], b[6]};
    dec_next.my = 16'd0 - {b[9], b[8]};
    dec_next.ml = b[12];
    dec_next.mr = b[13];
    dec_next.key = {b[15], b[14]};
  end

  always_comb begin
    mag_rx = magnitude(dec.rx);
    mag_ry = magnitude(dec.ry);
    mag_lx = magnitude(dec.lx);
    mag_ly = magnitude(dec.ly);
    zero_lx = (mag_lx <= {1'b0, left_x_zero});
    zero_ly = (mag_ly <= {1'b0, left_y_zero});
    reject = (mag_rx > {1'b0, stick_limit}) ||
             (mag_ry > {1'b0, stick_limit}) ||
             (!zero_lx && (mag_lx > {1'b0, stick_limit})) ||
             (!zero_ly && (mag_ly > {1'b0, stick_limit}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_h <= rfd_pkg::DEADZONE_H_RESET;
      deadzone_v <= rfd_pkg::DEADZONE_V_RESET;
      left_x_zero <= rfd_pkg::LEFT_X_ZERO_RESET;
      left_y_zero <= rfd_pkg::LEFT_Y_ZERO_RESET;
      stick_limit <= rfd_pkg::STICK_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfd_pkg::REG_DEADZONE_H:  deadzone_h <= cfg_data[7:0];
        rfd_pkg::REG_DEADZONE_V:  deadzone_v <= cfg_data[7:0];
        rfd_pkg::REG_LEFT_X_ZERO: left_x_zero <= cfg_data;
        rfd_pkg::REG_LEFT_Y_ZERO: left_y_zero <= cfg_data;
        rfd_pkg::REG_STICK_LIMIT: stick_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rfd_pkg::STORED_BYTES; i++) begin
        store[i] <= '0;
      end
      wpos <= '0;
      dec_valid <= 1'b0;
    end else begin
      dec_valid <= head.valid && (head.item.kind == rfd_pkg::ITEM_IDLE);
      if (head.valid) begin
        if (head.item.kind == rfd_pkg::ITEM_IDLE) begin
          wpos <= '0;
        end else if (wpos < rfd_pkg::WPOS_W'(rfd_pkg::STORED_BYTES)) begin
          store[wpos[rfd_pkg::STORE_AW-1:0]] <= head.item.data;
          wpos <= wpos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head.valid && (head.item.kind == rfd_pkg::ITEM_IDLE)) begin
      dec <= dec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid) begin
      key_bits <= dec.key;
      frame_rejected <= reject;
      if (reject) begin
        right_x <= '0;
        right_y <= '0;
        left_x <= '0;
        left_y <= '0;
        switch_left <= '0;
        switch_right <= '0;
        mouse_x <= '0;
        mouse_y <= '0;
        mouse_left <= '0;
        mouse_right <= '0;
      end else begin
        right_x <= dec.rx;
        right_y <= dec.ry;
        left_x <= zero_lx ? 11'sd0 : dec.lx;
        left_y <= zero_ly ? 11'sd0 : dec.ly;
        switch_left <= dec.sw_l;
        switch_right <= dec.sw_r;
        mouse_x <= $signed(dec.mx);
        mouse_y <= $signed(dec.my);
        mouse_left <= dec.ml;
        mouse_right <= dec.mr;
      end
    end
  end

  a_wpos_bound: assert property (@(posedge clk) disable iff (rst)
    wpos <= rfd_pkg::WPOS_W'(rfd_pkg::STORED_BYTES))
    else $error("write position beyond store");

  a_done_follows_decode: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(dec_valid))
    else $error("result strobe without a decoded frame");

  a_rejected_zeroed: assert property (@(posedge clk) disable iff (rst)
    done && frame_rejected |-> right_x == 11'sd0 && left_y == 11'sd0 &&
                               mouse_x == 16'sd0 && mouse_right == 8'd0)
    else $error("rejected frame carries nonzero fields");

  a_idle_rewinds: assert property (@(posedge clk) disable iff (rst)
    head.valid && head.item.kind == rfd_pkg::ITEM_IDLE |=> wpos == '0)
    else $error("idle did not rewind the write position");

endmodule

>>> rtl/remote_frame_decoder_top.sv
// Timing: an idle beat accepted into the queue is registered in dec and dec_valid, and then
// done rises together with the registered result outputs.
// Throughput: one beat per cycle; the back end drains the two-entry queue every
// cycle, so busy stays low and byte beats produce no result.
// Reset (rst, synchronous, active high) clears the byte store, the write position,
// the queue and the strobe, and loads the register reset values; the receiver cannot stall.
module remote_frame_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           idle,
  input  logic [7:0]                     rx_byte,
  input  logic                           cfg_we,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           done,
  output logic signed [10:0]             right_x,
  output logic signed [10:0]             right_y,
  output logic signed [10:0]             left_x,
  output logic signed [10:0]             left_y,
  output logic [1:0]                     switch_left,
  output logic [1:0]                     switch_right,
  output logic signed [15:0]             mouse_x,
  output logic signed [15:0]             mouse_y,
  output logic [7:0]                     mouse_left,
  output logic [7:0]                     mouse_right,
  output logic [15:0]                    key_bits,
  output logic                           frame_rejected
);

  rfd_pkg::queue_head_t head;
  logic                 pop;

  rfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .idle    (idle),
    .rx_byte (rx_byte),
    .pop     (pop),
    .busy    (busy),
    .head    (head)
  );

  rfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .right_x        (right_x),
    .right_y        (right_y),
    .left_x         (left_x),
    .left_y         (left_y),
    .switch_left    (switch_left),
    .switch_right   (switch_right),
    .mouse_x        (mouse_x),
    .mouse_y        (mouse_y),
    .mouse_left     (mouse_left),
    .mouse_right    (mouse_right),
    .key_bits       (key_bits),
    .frame_rejected (frame_rejected)
  );

endmodule
